// ----- rtl/core/pbba_pkg.sv -----
package pbba_pkg;

    // internal width for byte addresses and page indices
    localparam int BW  = 40;
    // bitmap memory word
    localparam int MW  = 64;
    localparam int MLW = 6;

    typedef enum logic [9:0] {
        S_CLR  = 10'b00_0000_0001,
        S_IDLE = 10'b00_0000_0010,
        S_DEC  = 10'b00_0000_0100,
        S_PREP = 10'b00_0000_1000,
        S_SKIP = 10'b00_0001_0000,
        S_CHK  = 10'b00_0010_0000,
        S_RUN  = 10'b00_0100_0000,
        S_PACK = 10'b00_1000_0000,
        S_MARK = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

    localparam logic [1:0] FN_FREE  = 2'd0;
    localparam logic [1:0] FN_RSV   = 2'd1;
    localparam logic [1:0] FN_ALLOC = 2'd2;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_ZERO    = 3'd1;
    localparam logic [2:0] STAT_RANGE   = 3'd2;
    localparam logic [2:0] STAT_DFREE   = 3'd3;
    localparam logic [2:0] STAT_DRSV    = 3'd4;
    localparam logic [2:0] STAT_NOSPACE = 3'd5;
    localparam logic [2:0] STAT_ALIGN   = 3'd6;

endpackage

// ----- rtl/core/pbba_ram.sv -----
module pbba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wa,
    input  logic [WIDTH-1:0]                      i_wd,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_ra,
    output logic [WIDTH-1:0]                      o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

// ----- rtl/core/page_bitmap_boot_allocator_core.sv -----
// boot-time page bitmap allocator for one memory node
// configuration: i_cfg_we writes register i_cfg_idx (0 base page, 1 end page) from
// i_cfg_wdata; write only while no transaction is in flight
// input transaction on s_axis: func, addr, size, align, goal, limit
// output transaction on m_axis: status and allocated byte address
// the bitmap sits in a ram of 64-bit words with a one-word cache in front of it;
// a word miss first writes back a dirty word, then reads the new word from the
// registered ram port; free and reserve visit every page in range, allocate
// scans pages until it finds a free run; one transaction at a time
// after reset a clearing pass writes every word of the bitmap with
// ones (every page reserved); s_axis_tready stays low until it is over
// the result waits in an output register; while the receiver stalls, the
// block finishes the current transaction and then holds before taking another
module page_bitmap_boot_allocator_core
    import pbba_pkg::*;
#(
    parameter int NUM_PAGES = 4096,
    parameter int PAGE_BITS = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [20:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[1:0], addr[33:2], size[58:34], align[83:59], goal[115:84], limit[147:116]
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], alloc_addr[34:3]
    output logic [39:0]  m_axis_tdata
);

    localparam int DEPTH = (NUM_PAGES + MW - 1) / MW;
    localparam int AWD   = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam logic [BW-1:0] PSIZE = BW'(1) << PAGE_BITS;
    localparam logic [BW-1:0] PMASK = PSIZE - BW'(1);

    function automatic logic [BW-1:0] ru(input logic [BW-1:0] x, input logic [BW-1:0] a);
        ru = (x + a - BW'(1)) & ~(a - BW'(1));
    endfunction

    t_state r_state;

    logic [19:0] r_base;
    logic [20:0] r_endp;

    logic [1:0]    r_func;
    logic [BW-1:0] r_addr, r_size, r_goal, r_limit, r_al;
    logic [24:0]   r_align;

    logic [BW-1:0] r_i, r_j, r_e, r_incr, r_area, r_pref, r_off;
    logic          r_second, r_setv;
    logic [2:0]    r_err, r_st;
    logic [BW-1:0] r_ret;

    logic [BW-1:0]        r_lso, r_lpi;
    logic [PAGE_BITS-1:0] r_lpf;

    logic          r_ovalid;
    logic [2:0]    r_ostat;
    logic [31:0]   r_oaddr;

    // word cache
    logic [MW-1:0]  r_cw;
    logic [AWD-1:0] r_ci, r_pi, r_clr;
    logic           r_cv, r_cd, r_pend;

    logic           mem_we, mem_re;
    logic [AWD-1:0] mem_wa, mem_ra;
    logic [MW-1:0]  mem_wd, mem_rd;

    pbba_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_ram (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa),
        .i_wd  (mem_wd),
        .i_re  (mem_re),
        .i_ra  (mem_ra),
        .o_rd  (mem_rd)
    );

    // node geometry
    logic [BW-1:0] w_base, w_ns, w_span, w_ne;
    assign w_base = BW'(r_base);
    assign w_ns   = w_base << PAGE_BITS;
    assign w_span = (BW'(r_endp) > w_base) ?
                    ((BW'(r_endp) - w_base > BW'(NUM_PAGES)) ? BW'(NUM_PAGES)
                                                             : BW'(r_endp) - w_base)
                    : '0;
    assign w_ne   = w_base + w_span;

    // free and reserve decode
    logic [BW-1:0] w_fendp, w_rendp;
    logic          w_fbad, w_rbad;
    assign w_fendp = (r_addr + r_size) >> PAGE_BITS;
    assign w_rendp = (r_addr + r_size + PMASK) >> PAGE_BITS;
    assign w_fbad  = (r_addr < w_ns) || (w_fendp > w_ne);
    assign w_rbad  = (r_addr < w_ns) || ((r_addr >> PAGE_BITS) >= w_ne) || (w_rendp > w_ne);

    // allocate decode
    logic [BW-1:0] w_al, w_limpg, w_efn, w_eidx, w_mis, w_off, w_gp, w_pref0, w_area, w_incr;
    logic          w_badal, w_gok, w_lsok;
    assign w_al    = (r_align == '0) ? BW'(1) : BW'(r_align);
    assign w_badal = |(w_al & (w_al - BW'(1)));
    assign w_limpg = r_limit >> PAGE_BITS;
    assign w_efn   = (w_limpg != '0 && w_ne > w_limpg) ? w_limpg : w_ne;
    assign w_eidx  = (w_efn > w_base) ? w_efn - w_base : '0;
    assign w_mis   = w_ns & (w_al - BW'(1));
    assign w_off   = ((w_mis != '0) ? w_al - w_mis : '0) >> PAGE_BITS;
    assign w_gok   = (r_goal != '0) && (r_goal >= w_ns) && ((r_goal >> PAGE_BITS) < w_efn);
    assign w_gp    = r_goal - w_ns;
    assign w_lsok  = (r_lso >= w_gp) && (r_limit == '0 || w_ns + r_lso < r_limit);
    assign w_pref0 = w_gok ? (w_lsok ? r_lso : w_gp) : '0;
    assign w_area  = (r_size + PMASK) >> PAGE_BITS;
    assign w_incr  = ((w_al >> PAGE_BITS) == '0) ? BW'(1) : (w_al >> PAGE_BITS);

    // scan helpers
    logic [BW-1:0] w_rui, w_ruj;
    assign w_rui = ru(r_i, r_incr);
    assign w_ruj = ru(r_j, r_incr) + r_incr;

    // packing into the partly used last page
    logic          w_pk, w_psmall;
    logic [BW-1:0] w_poff, w_prem, w_rem2, w_parea;
    assign w_pk     = (r_al < PSIZE) && (r_lpf != '0) && (r_lpi + BW'(1) == r_i);
    assign w_poff   = ru(BW'(r_lpf), r_al);
    assign w_prem   = PSIZE - w_poff;
    assign w_psmall = r_size < w_prem;
    assign w_rem2   = r_size - w_prem;
    assign w_parea  = (w_rem2 + PMASK) >> PAGE_BITS;

    // bit access through the word cache
    logic [BW-1:0]  a_idx;
    logic           a_req, a_oob, a_hit, a_bit;
    logic [AWD-1:0] a_widx;
    always_comb begin
        a_idx = r_i;
        a_req = 1'b0;
        unique case (r_state)
            S_SKIP: a_req = r_i < r_e;
            S_CHK:  a_req = 1'b1;
            S_RUN: begin
                a_idx = r_j;
                a_req = (r_j < r_i + r_area) && (r_j < r_e);
            end
            S_MARK: a_req = r_i < r_e;
            default: a_req = 1'b0;
        endcase
    end
    assign a_oob  = a_idx >= BW'(NUM_PAGES);
    assign a_widx = a_idx[MLW +: AWD];
    assign a_hit  = !r_pend && (a_oob || (r_cv && r_ci == a_widx));
    assign a_bit  = a_oob ? 1'b1 : r_cw[a_idx[MLW-1:0]];

    logic w_miss;
    assign w_miss = a_req && !a_hit && !r_pend;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_ci;
        mem_wd = r_cw;
        mem_re = 1'b0;
        mem_ra = a_widx;
        if (r_state == S_CLR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = '1;
        end else if (w_miss) begin
            if (r_cv && r_cd) begin
                mem_we = 1'b1;
            end else begin
                mem_re = 1'b1;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'b0, r_oaddr, r_ostat};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_base   <= '0;
            r_endp   <= 21'd4096;
            r_lso    <= '0;
            r_lpi    <= '0;
            r_lpf    <= '0;
            r_cv     <= 1'b0;
            r_cd     <= 1'b0;
            r_pend   <= 1'b0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx) begin
                    r_endp <= i_cfg_wdata;
                end else begin
                    r_base <= i_cfg_wdata[19:0];
                end
            end

            if (r_ovalid && m_axis_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end

            // cache fill and write back
            if (r_pend) begin
                r_cw   <= mem_rd;
                r_ci   <= r_pi;
                r_cv   <= 1'b1;
                r_pend <= 1'b0;
            end else if (w_miss) begin
                if (r_cv && r_cd) begin
                    r_cd <= 1'b0;
                end else begin
                    r_pend <= 1'b1;
                    r_pi   <= a_widx;
                end
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AWD'(1);
                    if (r_clr == AWD'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_func  <= s_axis_tdata[1:0];
                        r_addr  <= BW'(s_axis_tdata[33:2]);
                        r_size  <= BW'(s_axis_tdata[58:34]);
                        r_align <= s_axis_tdata[83:59];
                        r_goal  <= BW'(s_axis_tdata[115:84]);
                        r_limit <= BW'(s_axis_tdata[147:116]);
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_ret <= '0;
                    unique case (r_func)
                        FN_FREE: begin
                            if (r_size == '0) begin
                                r_st    <= STAT_ZERO;
                                r_state <= S_DONE;
                            end else if (w_fbad) begin
                                r_st    <= STAT_RANGE;
                                r_state <= S_DONE;
                            end else begin
                                if (r_addr - w_ns < r_lso) begin
                                    r_lso <= r_addr - w_ns;
                                end
                                r_st    <= STAT_OK;
                                r_i     <= ((r_addr + PMASK) >> PAGE_BITS) - w_base;
                                r_e     <= w_fendp - w_base;
                                r_setv  <= 1'b0;
                                r_err   <= STAT_DFREE;
                                r_state <= S_MARK;
                            end
                        end
                        FN_RSV: begin
                            if (r_size == '0) begin
                                r_st    <= STAT_ZERO;
                                r_state <= S_DONE;
                            end else if (w_rbad) begin
                                r_st    <= STAT_RANGE;
                                r_state <= S_DONE;
                            end else begin
                                r_st    <= STAT_OK;
                                r_i     <= (r_addr - w_ns) >> PAGE_BITS;
                                r_e     <= w_rendp - w_base;
                                r_setv  <= 1'b1;
                                r_err   <= STAT_DRSV;
                                r_state <= S_MARK;
                            end
                        end
                        FN_ALLOC: begin
                            if (r_size == '0) begin
                                r_st    <= STAT_ZERO;
                                r_state <= S_DONE;
                            end else if (w_badal) begin
                                r_st    <= STAT_ALIGN;
                                r_state <= S_DONE;
                            end else if (r_limit != '0 && w_ns >= r_limit) begin
                                r_st    <= STAT_NOSPACE;
                                r_state <= S_DONE;
                            end else begin
                                r_st     <= STAT_OK;
                                r_al     <= w_al;
                                r_e      <= w_eidx;
                                r_off    <= w_off;
                                r_pref   <= w_pref0;
                                r_area   <= w_area;
                                r_incr   <= w_incr;
                                r_second <= 1'b0;
                                r_state  <= S_PREP;
                            end
                        end
                        default: begin
                            r_st    <= STAT_RANGE;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_PREP: begin
                    r_pref  <= (ru(r_pref, r_al) >> PAGE_BITS) + r_off;
                    r_i     <= (ru(r_pref, r_al) >> PAGE_BITS) + r_off;
                    r_state <= S_SKIP;
                end
                S_SKIP: begin
                    if (r_i < r_e && !(a_hit && !a_bit)) begin
                        if (a_hit) begin
                            r_i <= r_i + BW'(1);
                        end
                    end else if (w_rui < r_e) begin
                        r_i     <= w_rui;
                        r_state <= S_CHK;
                    end else if (!r_second && r_pref > r_off) begin
                        // retry from the node base
                        r_second <= 1'b1;
                        r_i      <= r_off;
                    end else begin
                        r_st    <= STAT_NOSPACE;
                        r_state <= S_DONE;
                    end
                end
                S_CHK: begin
                    if (a_hit) begin
                        if (a_bit) begin
                            r_i     <= r_i + r_incr;
                            r_state <= S_SKIP;
                        end else begin
                            r_j     <= r_i + BW'(1);
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (r_j >= r_i + r_area) begin
                        r_state <= S_PACK;
                    end else if (r_j >= r_e) begin
                        r_i     <= w_ruj;
                        r_state <= S_SKIP;
                    end else if (a_hit) begin
                        if (a_bit) begin
                            r_i     <= w_ruj;
                            r_state <= S_SKIP;
                        end else begin
                            r_j <= r_j + BW'(1);
                        end
                    end
                end
                S_PACK: begin
                    r_lso  <= r_i << PAGE_BITS;
                    r_setv <= 1'b1;
                    r_err  <= STAT_OK;
                    if (w_pk) begin
                        r_ret <= w_ns + (r_lpi << PAGE_BITS) + w_poff;
                        if (w_psmall) begin
                            r_e   <= r_i;
                            r_lpf <= PAGE_BITS'(w_poff + r_size);
                        end else begin
                            r_e   <= r_i + w_parea;
                            r_lpi <= r_i + w_parea - BW'(1);
                            r_lpf <= PAGE_BITS'(w_rem2);
                        end
                    end else begin
                        r_ret <= w_ns + (r_i << PAGE_BITS);
                        r_e   <= r_i + r_area;
                        r_lpi <= r_i + r_area - BW'(1);
                        r_lpf <= PAGE_BITS'(r_size);
                    end
                    r_state <= S_MARK;
                end
                S_MARK: begin
                    if (r_i >= r_e) begin
                        r_state <= S_DONE;
                    end else if (a_hit) begin
                        if (a_bit == r_setv) begin
                            r_st <= r_err;
                        end
                        if (!a_oob) begin
                            r_cw[a_idx[MLW-1:0]] <= r_setv;
                            r_cd <= 1'b1;
                        end
                        r_i <= r_i + BW'(1);
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_ostat  <= r_st;
                        r_oaddr  <= (r_st == STAT_OK) ? r_ret[31:0] : 32'd0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
